@@ src/assert_macros.svh @@
// Assertion macros used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/tev_pkg.sv @@
// Types and constants of the timed event queue.
package tev_pkg;

   localparam int Depth      = 64;
   localparam int SlotBits   = $clog2(Depth);
   localparam int LinkBits   = SlotBits + 1;
   localparam int CountBits  = $clog2(Depth + 1);
   localparam int RunCap     = 30;
   localparam int HandleBits = 32;

   localparam logic [LinkBits-1:0] NullLink = LinkBits'(Depth);

   localparam logic [1:0] CSR_MAX_TOTAL    = 2'd0;
   localparam logic [1:0] CSR_MAX_PER_USER = 2'd1;
   localparam logic [1:0] CSR_MAX_RUNS     = 2'd2;

   typedef enum logic [1:0] {
      MODE_SCHEDULE,
      MODE_TICK,
      MODE_CANCEL,
      MODE_READ_DONE
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED,
      KIND_REFUSED,
      KIND_RELEASED,
      KIND_CANCELLED,
      KIND_NO_ID,
      KIND_READ_DELIVERED,
      KIND_NO_WAIT,
      KIND_IDLE
   } kind_type;

   typedef struct packed {
      mode_type     mode;
      logic [31:0]  now;
      logic [23:0]  delay;
      logic         is_wait;
      logic [15:0]  user;
      logic         privileged;
      logic [15:0]  target_id;
      logic [31:0]  payload;
   } req_type;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  event_id;
      logic [15:0]  owner;
      logic [31:0]  handle;
      logic         more_waits;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic [5:0] max_total;
      logic [5:0] max_per_user;
      logic [4:0] max_runs;
   } cfg_type;

   typedef struct packed {
      logic [31:0]           due;
      logic [15:0]           owner;
      logic [15:0]           ident;
      logic [HandleBits-1:0] handle;
      logic                  waiting;
      logic [LinkBits-1:0]   next;
   } entry_type;

endpackage

@@ src/tev_ram.sv @@
// Entry store: one write port, one read port with registered read data.
module tev_ram
   import tev_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SlotBits-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic                rd_en,
   input  logic [SlotBits-1:0] rd_addr,
   output entry_type           rd_data
);

   entry_type mem_ff [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tev_seq.sv @@
// Sequencer: walks the linked order in the entry store and produces result words.
`include "assert_macros.svh"
module tev_seq
   import tev_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DECIDE,
      ST_LINK,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_EMIT
   } state_type;

   state_type            state_ff, ret_ff;
   req_type              req_ff;
   logic [31:0]          due_ff;
   logic [LinkBits-1:0]  head_ff;
   logic [CountBits-1:0] count_ff, mine_ff;
   logic [15:0]          id_ff;
   logic [Depth-1:0]     used_ff;
   logic [SlotBits-1:0]  cur_slot_ff, prev_slot_ff, new_slot_ff;
   entry_type            prev_ent_ff, hit_ent_ff, pend_ff;
   logic                 have_prev_ff, found_ff, hit_ff, more_ff, pend_valid_ff;
   logic [LinkBits-1:0]  succ_ff;
   logic [4:0]           runs_ff;
   rsp_type              res_ff, rsp_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en, rd_en;
   logic [SlotBits-1:0]  wr_addr, rd_addr;
   entry_type            wr_data, rd_data;

   logic                 accept, out_free, next_null, own_match, goes_before;
   logic                 id_match, wait_match, unlink_now, tick_due, refuse, free_found;
   logic [SlotBits-1:0]  free_slot;
   logic [4:0]           limit;
   logic [32:0]          due_sum;
   logic                 hit_now, more_now;
   entry_type            hit_ent;

   tev_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign due_sum     = {1'b0, req_payload.now} + {9'b0, req_payload.delay};
   assign limit       = (cfg.max_runs > 5'(RunCap)) ? 5'(RunCap) : cfg.max_runs;
   assign next_null   = (rd_data.next == NullLink);
   assign own_match   = (rd_data.owner == req_ff.user);
   assign goes_before = !req_ff.is_wait && ((due_ff < rd_data.due) || rd_data.waiting);
   assign id_match    = (rd_data.ident == req_ff.target_id);
   assign wait_match  = rd_data.waiting && own_match;
   assign tick_due    = !rd_data.waiting && (rd_data.due <= req_ff.now);
   assign unlink_now  = (state_ff == ST_WALK) &&
                        (((req_ff.mode == MODE_CANCEL) && id_match) ||
                         ((req_ff.mode == MODE_READ_DONE) && !hit_ff && wait_match));
   assign hit_now     = hit_ff || wait_match;
   assign hit_ent     = hit_ff ? hit_ent_ff : rd_data;
   assign more_now    = more_ff || (hit_ff && wait_match);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = Depth - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SlotBits'(i);
         end
      end
   end

   assign refuse = !free_found ||
                   (!req_ff.is_wait &&
                    ((count_ff > CountBits'(cfg.max_total)) ||
                     ((mine_ff > CountBits'(cfg.max_per_user)) && !req_ff.privileged)));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff[SlotBits-1:0];
      case (state_ff)
         ST_IDLE: begin
            rd_en = accept && (head_ff != NullLink) &&
                    ((req_payload.mode == MODE_SCHEDULE) ||
                     (req_payload.mode == MODE_READ_DONE) ||
                     ((req_payload.mode == MODE_CANCEL) && (req_payload.target_id != '0)));
         end
         ST_WALK: begin
            rd_en   = !next_null && !((req_ff.mode == MODE_CANCEL) && id_match);
            rd_addr = rd_data.next[SlotBits-1:0];
         end
         ST_TICK_RD: begin
            rd_en = (runs_ff < limit) && (head_ff != NullLink);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = prev_slot_ff;
      wr_data = prev_ent_ff;
      case (state_ff)
         ST_WALK: begin
            wr_en        = unlink_now && have_prev_ff;
            wr_data.next = rd_data.next;
         end
         ST_DECIDE: begin
            wr_en           = !refuse;
            wr_addr         = free_slot;
            wr_data.due     = due_ff;
            wr_data.owner   = req_ff.user;
            wr_data.ident   = id_ff;
            wr_data.handle  = req_ff.payload[HandleBits-1:0];
            wr_data.waiting = req_ff.is_wait;
            wr_data.next    = succ_ff;
         end
         ST_LINK: begin
            wr_en        = have_prev_ff;
            wr_data.next = {1'b0, new_slot_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cur_slot_ff <= rd_addr;
      end
      if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_ff        <= req_payload;
               due_ff        <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
               mine_ff       <= '0;
               found_ff      <= 1'b0;
               succ_ff       <= NullLink;
               have_prev_ff  <= 1'b0;
               hit_ff        <= 1'b0;
               more_ff       <= 1'b0;
               runs_ff       <= '0;
               pend_valid_ff <= 1'b0;
               ret_ff        <= ST_IDLE;
               case (req_payload.mode)
                  MODE_SCHEDULE: begin
                     state_ff <= (head_ff == NullLink) ? ST_DECIDE : ST_WALK;
                  end
                  MODE_TICK: begin
                     state_ff <= ST_TICK_RD;
                  end
                  MODE_CANCEL: begin
                     if ((req_payload.target_id == '0) || (head_ff == NullLink)) begin
                        res_ff   <= '{kind: KIND_NO_ID, event_id: '0, owner: '0,
                                      handle: '0, more_waits: 1'b0, last: 1'b1};
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_WALK;
                     end
                  end
                  default: begin
                     if (head_ff == NullLink) begin
                        res_ff   <= '{kind: KIND_NO_WAIT, event_id: '0,
                                      owner: req_payload.user, handle: '0,
                                      more_waits: 1'b0, last: 1'b1};
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (unlink_now) begin
               if (!have_prev_ff) begin
                  head_ff <= rd_data.next;
               end
               used_ff[cur_slot_ff] <= 1'b0;
               count_ff             <= count_ff - 1'b1;
            end
            case (req_ff.mode)
               MODE_SCHEDULE: begin
                  if (own_match) begin
                     mine_ff <= mine_ff + 1'b1;
                  end
                  if (!found_ff) begin
                     if (goes_before) begin
                        found_ff <= 1'b1;
                        succ_ff  <= {1'b0, cur_slot_ff};
                     end else begin
                        prev_slot_ff <= cur_slot_ff;
                        prev_ent_ff  <= rd_data;
                        have_prev_ff <= 1'b1;
                     end
                  end
                  if (next_null) begin
                     state_ff <= ST_DECIDE;
                  end
               end
               MODE_CANCEL: begin
                  if (id_match) begin
                     res_ff   <= '{kind: KIND_CANCELLED, event_id: rd_data.ident,
                                   owner: rd_data.owner, handle: 32'(rd_data.handle),
                                   more_waits: 1'b0, last: 1'b1};
                     state_ff <= ST_EMIT;
                  end else begin
                     prev_slot_ff <= cur_slot_ff;
                     prev_ent_ff  <= rd_data;
                     have_prev_ff <= 1'b1;
                     if (next_null) begin
                        res_ff   <= '{kind: KIND_NO_ID, event_id: '0, owner: '0,
                                      handle: '0, more_waits: 1'b0, last: 1'b1};
                        state_ff <= ST_EMIT;
                     end
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     if (wait_match) begin
                        hit_ff     <= 1'b1;
                        hit_ent_ff <= rd_data;
                     end else begin
                        prev_slot_ff <= cur_slot_ff;
                        prev_ent_ff  <= rd_data;
                        have_prev_ff <= 1'b1;
                     end
                  end else if (wait_match) begin
                     more_ff <= 1'b1;
                  end
                  if (next_null) begin
                     if (hit_now) begin
                        res_ff <= '{kind: KIND_READ_DELIVERED, event_id: hit_ent.ident,
                                    owner: req_ff.user, handle: 32'(hit_ent.handle),
                                    more_waits: more_now, last: 1'b1};
                     end else begin
                        res_ff <= '{kind: KIND_NO_WAIT, event_id: '0, owner: req_ff.user,
                                    handle: '0, more_waits: 1'b0, last: 1'b1};
                     end
                     state_ff <= ST_EMIT;
                  end
               end
            endcase
         end
         ST_DECIDE: begin
            if (refuse) begin
               res_ff   <= '{kind: KIND_REFUSED, event_id: '0, owner: req_ff.user,
                             handle: '0, more_waits: 1'b0, last: 1'b1};
               state_ff <= ST_EMIT;
            end else begin
               used_ff[free_slot] <= 1'b1;
               count_ff           <= count_ff + 1'b1;
               id_ff              <= (id_ff == 16'hFFFF) ? 16'd1 : id_ff + 16'd1;
               new_slot_ff        <= free_slot;
               res_ff             <= '{kind: KIND_ACCEPTED, event_id: id_ff,
                                       owner: req_ff.user,
                                       handle: 32'(req_ff.payload[HandleBits-1:0]),
                                       more_waits: 1'b0, last: 1'b1};
               state_ff           <= ST_LINK;
            end
         end
         ST_LINK: begin
            if (!have_prev_ff) begin
               head_ff <= {1'b0, new_slot_ff};
            end
            state_ff <= ST_EMIT;
         end
         ST_TICK_RD: begin
            if (rd_en) begin
               state_ff <= ST_TICK_CHK;
            end else begin
               if (pend_valid_ff) begin
                  res_ff <= '{kind: KIND_RELEASED, event_id: pend_ff.ident,
                              owner: pend_ff.owner, handle: 32'(pend_ff.handle),
                              more_waits: 1'b0, last: 1'b1};
               end else begin
                  res_ff <= '{kind: KIND_IDLE, event_id: '0, owner: '0, handle: '0,
                              more_waits: 1'b0, last: 1'b1};
               end
               ret_ff   <= ST_IDLE;
               state_ff <= ST_EMIT;
            end
         end
         ST_TICK_CHK: begin
            if (tick_due) begin
               // pop the head; the previous pop goes out now, not the last word
               head_ff              <= rd_data.next;
               used_ff[cur_slot_ff] <= 1'b0;
               count_ff             <= count_ff - 1'b1;
               runs_ff              <= runs_ff + 1'b1;
               pend_ff              <= rd_data;
               pend_valid_ff        <= 1'b1;
               if (pend_valid_ff) begin
                  res_ff   <= '{kind: KIND_RELEASED, event_id: pend_ff.ident,
                                owner: pend_ff.owner, handle: 32'(pend_ff.handle),
                                more_waits: 1'b0, last: 1'b0};
                  ret_ff   <= ST_TICK_RD;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_TICK_RD;
               end
            end else begin
               if (pend_valid_ff) begin
                  res_ff <= '{kind: KIND_RELEASED, event_id: pend_ff.ident,
                              owner: pend_ff.owner, handle: 32'(pend_ff.handle),
                              more_waits: 1'b0, last: 1'b1};
               end else begin
                  res_ff <= '{kind: KIND_IDLE, event_id: '0, owner: '0, handle: '0,
                              more_waits: 1'b0, last: 1'b1};
               end
               ret_ff   <= ST_IDLE;
               state_ff <= ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_ff       <= res_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ret_ff;
            end
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         head_ff      <= NullLink;
         count_ff     <= '0;
         id_ff        <= 16'd1;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= CountBits'(Depth), "count above depth")
   `ASSERT_IMPL(a_used_count, clock, reset, state_ff == ST_IDLE, $countones(used_ff) == int'(count_ff), "used bits disagree with count")
   `ASSERT_IMPL(a_empty_head, clock, reset, state_ff == ST_IDLE && head_ff == NullLink, count_ff == '0, "empty list with entries counted")
   `ASSERT_IMPL(a_start, clock, reset, $past(accept) && !$past(reset), state_ff != ST_IDLE, "accepted word left no work")

endmodule

@@ src/timed_event_queue.sv @@
// Top level of the timed event queue: configuration registers and sequencer.
// Each request word yields one result word, or for a tick one word per released
// entry (at most max_runs, capped at 30). Schedule, cancel and read done walk the
// linked order in the entry store (one write port, one read port), one entry per
// cycle; a tick pops due entries from the head. A schedule walks the whole order,
// then decides, links and emits its result; cancel stops at the matching entry and
// read done walks the whole order to see whether more waits remain. Results leave
// through an output register, so a new request is taken while the last result
// still waits. Slot occupancy lives in flip-flops cleared by reset; there is no
// clearing pass. Configuration writes are always ready.
module timed_event_queue
   import tev_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{max_total: 6'd56, max_per_user: 6'd8, max_runs: 5'd30};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_TOTAL:    cfg_ff.max_total    <= csr_wdata;
            CSR_MAX_PER_USER: cfg_ff.max_per_user <= csr_wdata;
            CSR_MAX_RUNS:     cfg_ff.max_runs     <= csr_wdata[4:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   tev_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the timed event queue.
`timescale 1ns / 1ps
module tb_top;
   import tev_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;

   timed_event_queue uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the store
   logic [31:0] sh_due [Depth];
   logic [15:0] sh_owner [Depth];
   logic [15:0] sh_ident [Depth];
   logic [31:0] sh_handle [Depth];
   logic        sh_wait [Depth];
   logic        sh_used [Depth];
   int          sh_next [Depth];
   int          sh_head;
   int          sh_count;
   logic [15:0] sh_id_ctr;
   logic [5:0]  lim_total, lim_user;
   logic [4:0]  lim_runs;

   req_type     pending_words[$];
   rsp_type     expected_rsp[$];
   int          err_count = 0;
   int          rsp_seen = 0;
   int          req_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      err_count++;
   endtask

   function automatic rsp_type mk_rsp(kind_type k, logic [15:0] id, logic [15:0] own,
                                      logic [31:0] h, logic more);
      rsp_type r;
      r.kind = k; r.event_id = id; r.owner = own; r.handle = h;
      r.more_waits = more; r.last = 1'b0;
      return r;
   endfunction

   task automatic drop_slot(input int prev, input int s);
      if (prev >= Depth) sh_head = sh_next[s];
      else sh_next[prev] = sh_next[s];
      sh_used[s] = 1'b0;
      if (sh_count > 0) sh_count--;
   endtask

   task automatic predict_queue(input req_type w);
      rsp_type res[$];
      logic [32:0] sum;
      logic [31:0] due;
      int mine, s, p, prev, lim;
      logic more;
      case (w.mode)
         MODE_SCHEDULE: begin
            sum = {1'b0, w.now} + {9'b0, w.delay};
            due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            mine = 0;
            for (p = sh_head; p < Depth; p = sh_next[p])
               if (sh_owner[p] == w.user) mine++;
            for (s = 0; s < Depth && sh_used[s]; s++) ;
            if (s >= Depth || (!w.is_wait && (sh_count > lim_total ||
                  (mine > lim_user && !w.privileged)))) begin
               res.push_back(mk_rsp(KIND_REFUSED, 0, w.user, 0, 0));
            end else begin
               sh_used[s] = 1; sh_due[s] = due; sh_owner[s] = w.user;
               sh_ident[s] = sh_id_ctr; sh_handle[s] = w.payload; sh_wait[s] = w.is_wait;
               sh_id_ctr++;
               if (sh_id_ctr == 0) sh_id_ctr = 1;
               sh_count++;
               if (sh_head >= Depth) begin
                  sh_next[s] = Depth; sh_head = s;
               end else if (!w.is_wait && (due < sh_due[sh_head] || sh_wait[sh_head])) begin
                  sh_next[s] = sh_head; sh_head = s;
               end else begin
                  p = sh_head;
                  while (sh_next[p] < Depth && (w.is_wait ||
                         (due >= sh_due[sh_next[p]] && !sh_wait[sh_next[p]])))
                     p = sh_next[p];
                  sh_next[s] = sh_next[p]; sh_next[p] = s;
               end
               res.push_back(mk_rsp(KIND_ACCEPTED, sh_ident[s], w.user, w.payload, 0));
            end
         end
         MODE_TICK: begin
            lim = lim_runs > RunCap ? RunCap : lim_runs;
            while (res.size() < lim && sh_head < Depth) begin
               s = sh_head;
               if (sh_wait[s] || sh_due[s] > w.now) break;
               drop_slot(Depth, s);
               res.push_back(mk_rsp(KIND_RELEASED, sh_ident[s], sh_owner[s], sh_handle[s], 0));
            end
            if (res.size() == 0) res.push_back(mk_rsp(KIND_IDLE, 0, 0, 0, 0));
         end
         MODE_CANCEL: begin
            prev = Depth;
            p = sh_head;
            if (w.target_id != 0)
               while (p < Depth && sh_ident[p] != w.target_id) begin
                  prev = p; p = sh_next[p];
               end
            if (w.target_id != 0 && p < Depth) begin
               drop_slot(prev, p);
               res.push_back(mk_rsp(KIND_CANCELLED, w.target_id, sh_owner[p], sh_handle[p], 0));
            end else begin
               res.push_back(mk_rsp(KIND_NO_ID, 0, 0, 0, 0));
            end
         end
         default: begin
            prev = Depth;
            p = sh_head;
            while (p < Depth && !(sh_wait[p] && sh_owner[p] == w.user)) begin
               prev = p; p = sh_next[p];
            end
            if (p >= Depth) begin
               res.push_back(mk_rsp(KIND_NO_WAIT, 0, w.user, 0, 0));
            end else begin
               drop_slot(prev, p);
               more = 0;
               for (s = sh_next[p]; s < Depth; s = sh_next[s])
                  if (sh_wait[s] && sh_owner[s] == w.user) more = 1;
               res.push_back(mk_rsp(KIND_READ_DELIVERED, sh_ident[p], w.user,
                                    sh_handle[p], more));
            end
         end
      endcase
      res[res.size()-1].last = 1'b1;
      foreach (res[i]) expected_rsp.push_back(res[i]);
   endtask

   // the accept flag is taken from the rising edge, counted on the next falling one
   logic req_took = 1'b0;
   always @(posedge clock) req_took <= req_valid && req_ready;

   // driver: present words at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_took) req_sent++;
         if (!req_valid || req_took) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_words[0];
               req_valid <= 1'b1;
               predict_queue(pending_words.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_payload, '0);
         end else begin
            exp = expected_rsp.pop_front();
            if (rsp_payload.kind != exp.kind) report_mismatch("kind", rsp_payload, exp);
            else if (rsp_payload.event_id != exp.event_id)
               report_mismatch("event_id", rsp_payload, exp);
            else if (rsp_payload.owner != exp.owner) report_mismatch("owner", rsp_payload, exp);
            else if (rsp_payload.handle != exp.handle) report_mismatch("handle", rsp_payload, exp);
            else if (rsp_payload.more_waits != exp.more_waits)
               report_mismatch("more_waits", rsp_payload, exp);
            else if (rsp_payload.last != exp.last) report_mismatch("last", rsp_payload, exp);
         end
      end
   end

   function automatic req_type mk_req(mode_type m, logic [31:0] now, logic [23:0] dly,
                                      logic wt, logic [15:0] usr, logic pv,
                                      logic [15:0] tid, logic [31:0] pl);
      req_type r;
      r.mode = m; r.now = now; r.delay = dly; r.is_wait = wt; r.user = usr;
      r.privileged = pv; r.target_id = tid; r.payload = pl;
      return r;
   endfunction

   function automatic req_type rand_req(logic [31:0] base);
      req_type r;
      int sel;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      sel = $urandom_range(99);
      r.user = $urandom_range(5);
      if (sel < 3) r.user = $urandom;
      if ($urandom_range(3) != 0) r.now = base + $urandom_range(200);
      if ($urandom_range(4) != 0) r.delay = $urandom_range(150);
      r.target_id = sh_id_ctr - $urandom_range(1, 40);
      if (sel < 5) r.target_id = $urandom;
      if (sel < 45) r.mode = MODE_SCHEDULE;
      else if (sel < 70) r.mode = MODE_TICK;
      else if (sel < 85) r.mode = MODE_CANCEL;
      else r.mode = MODE_READ_DONE;
      r.is_wait = $urandom_range(4) == 0;
      return r;
   endfunction

   task automatic wait_idle();
      while (pending_words.size() > 0 || expected_rsp.size() > 0 || req_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_TOTAL: lim_total = val;
         CSR_MAX_PER_USER: lim_user = val;
         CSR_MAX_RUNS: lim_runs = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int ph;
      logic [31:0] base;
      for (int i = 0; i < Depth; i++) begin
         sh_used[i] = 0; sh_next[i] = 0; sh_due[i] = 0; sh_owner[i] = 0;
         sh_ident[i] = 0; sh_handle[i] = 0; sh_wait[i] = 0;
      end
      sh_head = Depth; sh_count = 0; sh_id_ctr = 1;
      lim_total = 56; lim_user = 8; lim_runs = 30;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      pending_words.push_back(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk_req(MODE_CANCEL, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk_req(MODE_READ_DONE, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 32'hFFFF_FFF0, 24'hFF_FFFF, 0,
                                     16'hFFFF, 1, 16'hFFFF, 32'hFFFF_FFFF));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 10, 0, 0, 1, 0, 0, 32'h1111));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 10, 0, 0, 2, 0, 0, 32'h2222));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 5, 0, 1, 1, 0, 0, 32'h3333));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 5, 3, 1, 1, 0, 0, 32'h4444));
      pending_words.push_back(mk_req(MODE_SCHEDULE, 3, 2, 0, 3, 0, 0, 32'h5555));
      pending_words.push_back(mk_req(MODE_CANCEL, 0, 0, 0, 0, 0, 3, 0));
      pending_words.push_back(mk_req(MODE_READ_DONE, 0, 0, 0, 1, 0, 0, 0));
      pending_words.push_back(mk_req(MODE_READ_DONE, 0, 0, 0, 1, 0, 0, 0));
      pending_words.push_back(mk_req(MODE_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
      wait_idle();

      // random phases over several limit settings and idling patterns
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MAX_TOTAL, 6'd63); write_reg(CSR_MAX_PER_USER, 6'd63);
                     write_reg(CSR_MAX_RUNS, 6'd30); end
            1: begin write_reg(CSR_MAX_TOTAL, 6'd0); write_reg(CSR_MAX_PER_USER, 6'd0);
                     write_reg(CSR_MAX_RUNS, 6'd1); end
            2: begin write_reg(CSR_MAX_TOTAL, 6'd12); write_reg(CSR_MAX_PER_USER, 6'd3);
                     write_reg(CSR_MAX_RUNS, 6'd31); end
            3: begin write_reg(CSR_MAX_RUNS, 6'd0); write_reg(2'd3, 6'd5); end
            4: begin write_reg(CSR_MAX_TOTAL, 6'd63); write_reg(CSR_MAX_PER_USER, 6'd20);
                     write_reg(CSR_MAX_RUNS, 6'd4); end
            5: write_reg(CSR_MAX_RUNS, 6'd2);
            6: begin write_reg(CSR_MAX_TOTAL, 6'd40); write_reg(CSR_MAX_PER_USER, 6'd8); end
            default: write_reg(CSR_MAX_RUNS, 6'd30);
         endcase
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 26 : 51) : 0;
         recv_stall_pct = (ph % 4 == 2) ? 51 : (ph % 4 == 3 ? 26 : 0);
         base = $urandom;
         // the full store is reached in the first phase with 70 schedules
         for (int i = 0; i < (ph == 0 ? 70 : 28); i++) begin
            pending_words.push_back(rand_req(base));
            if (ph == 0) pending_words[pending_words.size()-1].mode = MODE_SCHEDULE;
            base += $urandom_range(20);
         end
         wait_idle();
      end
      send_idle_pct = 0; recv_stall_pct = 0;
      $display("covered all four operations, every register and a full store");
      $display("%0d request words sent, %0d result words checked", req_sent, rsp_seen);
      if (err_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #8000000;
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
